/* src/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point arctangent
// pipeline context struct, Q62 constants and Hart polynomial coefficients
// ----------------------------------------------------------------------------
package fpa_pkg;

    // quotient bits produced by the restoring dividers
    localparam int Q_BITS = 63;

    localparam logic [63:0] DEC_E11  = 64'd100000000000;
    localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_Q62 = 64'h2000_0000_0000_0000;

    // decimal constant (integer part, two groups of 11 fraction digits) to Q62,
    // round to nearest; evaluated at elaboration only
    function automatic logic [63:0] q62_of(input logic [63:0] ip,
                                           input logic [63:0] hi_in,
                                           input logic [63:0] lo_in);
        logic [63:0] h;
        logic [63:0] l;
        logic [63:0] q;
        int          i;
        h = hi_in;
        l = lo_in;
        q = '0;
        for (i = 0; i < 63; i++) begin
            l = l << 1;
            h = h << 1;
            if (l >= DEC_E11) begin
                l = l - DEC_E11;
                h = h + 64'd1;
            end
            q = q << 1;
            if (h >= DEC_E11) begin
                h = h - DEC_E11;
                q = q | 64'd1;
            end
        end
        return ((q + 64'd1) >> 1) + ((ip & 64'd3) << 62);
    endfunction

    localparam logic [63:0] C_TAN15    = q62_of(64'd0, 64'd26794919243, 64'd11227074725);
    localparam logic [63:0] C_HALF_PI  = q62_of(64'd1, 64'd57079632679, 64'd48966192313);
    localparam logic [63:0] C_SIXTH_PI = q62_of(64'd0, 64'd52359877559, 64'd82988730771);
    localparam logic [63:0] C_SQRT3    = q62_of(64'd1, 64'd73205080756, 64'd88772935274);

    localparam logic signed [63:0] C_COEF [0:8] = '{
        q62_of(64'd0, 64'd99999999999, 64'd99999849899),
        -q62_of(64'd0, 64'd33333333333, 64'd32993087170),
        q62_of(64'd0, 64'd19999999998, 64'd72944792000),
        -q62_of(64'd0, 64'd14285714102, 64'd82554520000),
        q62_of(64'd0, 64'd11111097898, 64'd5104800000),
        -q62_of(64'd0, 64'd9090371141, 64'd91074000000),
        q62_of(64'd0, 64'd7679368690, 64'd66000000000),
        -q62_of(64'd0, 64'd6483193510, 64'd30300000000),
        q62_of(64'd0, 64'd4438951571, 64'd87000000000)
    };

    // everything an item carries down the pipeline
    typedef struct packed {
        logic        valid;
        logic        arg_neg;
        logic        invert;
        logic        sixth;
        logic        r_neg;
        logic        bypass;
        logic [31:0] mag;
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] z;
    } t_ctx;

endpackage

/* src/fpa_div.sv */
// ----------------------------------------------------------------------------
// fpa_div: pipelined restoring divider
// one quotient bit per stage, Q_BITS stages, context travels alongside
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int W = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [W-1:0]                  i_num,
    input  logic [W-1:0]                  i_den,
    input  fpa_pkg::t_ctx                 i_ctx,
    output logic [fpa_pkg::Q_BITS-1:0]    o_q,
    output fpa_pkg::t_ctx                 o_ctx
);
    localparam int N = fpa_pkg::Q_BITS;

    logic [W-1:0]   r_rem [N];
    logic [W-1:0]   r_den [N];
    logic [N-1:0]   r_q   [N];
    fpa_pkg::t_ctx  r_ctx [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0]  rem_in;
        logic [W-1:0]  den_in;
        logic [N-1:0]  q_in;
        fpa_pkg::t_ctx ctx_in;
        logic [W:0]    shifted;
        logic [W-1:0]  diff;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign ctx_in = i_ctx;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign ctx_in = r_ctx[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign take    = shifted >= {1'b0, den_in};
        assign diff    = shifted[W-1:0] - den_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctx[k].valid <= 1'b0;
            end else if (i_en) begin
                r_ctx[k] <= ctx_in;
                r_rem[k] <= take ? diff : shifted[W-1:0];
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[N-2:0], take};
            end
        end
    end

    assign o_q   = r_q[N-1];
    assign o_ctx = r_ctx[N-1];

endmodule

/* src/fpa_mul.sv */
// ----------------------------------------------------------------------------
// fpa_mul: signed Q62 multiplier, five stages
// magnitude, 32x32 partial products, middle sum, rounded sum, sign
// ----------------------------------------------------------------------------
module fpa_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    input  fpa_pkg::t_ctx       i_ctx,
    output logic signed [63:0]  o_p,
    output fpa_pkg::t_ctx       o_ctx
);
    localparam logic [127:0] RND = 128'(1) << 61;

    fpa_pkg::t_ctx r_ctx [5];

    logic [63:0]  r_ma, r_mb;
    logic         r_neg0, r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [64:0]  r_mid;
    logic [127:0] r_lohi;
    logic [63:0]  r_mag;
    logic signed [63:0] r_p;

    logic [63:0]  n_ma, n_mb;
    logic [127:0] n_sum;

    assign n_ma  = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign n_mb  = i_b[63] ? 64'(-i_b) : 64'(i_b);
    assign n_sum = r_lohi + (128'(r_mid) << 32) + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx[0].valid <= 1'b0;
            r_ctx[1].valid <= 1'b0;
            r_ctx[2].valid <= 1'b0;
            r_ctx[3].valid <= 1'b0;
            r_ctx[4].valid <= 1'b0;
        end else if (i_en) begin
            r_ctx[0] <= i_ctx;
            r_ma     <= n_ma;
            r_mb     <= n_mb;
            r_neg0   <= i_a[63] ^ i_b[63];

            r_ctx[1] <= r_ctx[0];
            r_neg1   <= r_neg0;
            r_p00    <= r_ma[31:0]  * r_mb[31:0];
            r_p01    <= r_ma[31:0]  * r_mb[63:32];
            r_p10    <= r_ma[63:32] * r_mb[31:0];
            r_p11    <= r_ma[63:32] * r_mb[63:32];

            r_ctx[2] <= r_ctx[1];
            r_neg2   <= r_neg1;
            r_mid    <= 65'(r_p01) + 65'(r_p10);
            r_lohi   <= {r_p11, r_p00};

            r_ctx[3] <= r_ctx[2];
            r_neg3   <= r_neg2;
            r_mag    <= n_sum[125:62];

            r_ctx[4] <= r_ctx[3];
            r_p      <= r_neg3 ? -$signed(r_mag) : $signed(r_mag);
        end
    end

    assign o_p   = r_p;
    assign o_ctx = r_ctx[4];

endmodule

/* src/fixed_point_arctangent_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_arctangent_top: Q16.16 argument in, Q2.29 arctangent out
// throughput: one request per cycle; a held output stalls every stage at once
// the two 63-stage dividers and the multiplier chain of Horner set the depth
// reset: synchronous active low, clears all stage valid bits and the limit
// ----------------------------------------------------------------------------
module fixed_point_arctangent_top #(
    parameter int ARG_FRAC_BITS   = 16,
    parameter int ANGLE_FRAC_BITS = 29,
    parameter int POLY_DEGREE     = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // bypass limit register
    input  logic                             i_cfg_we,
    input  logic [14:0]                      i_cfg_wdata,
    // argument request
    input  logic                             i_arg_valid,
    output logic                             o_arg_ready,
    input  logic signed [31:0]               i_arg_value,
    // angle result
    output logic                             o_angle_valid,
    input  logic                             i_angle_ready,
    output logic signed [ANGLE_FRAC_BITS+1:0] o_angle_value
);
    localparam int AW = ANGLE_FRAC_BITS + 2;
    localparam int SH = 62 - ANGLE_FRAC_BITS;
    localparam logic [31:0] ONE_ARG = 32'(1) << ARG_FRAC_BITS;
    localparam logic [63:0] RND_OUT = 64'(1) << (SH - 1);

    // whole pipeline moves together; it only halts when a result is held
    logic en;
    assign en          = !o_angle_valid || i_angle_ready;
    assign o_arg_ready = en;

    // bypass limit, to be written by the user only while idle; the block itself does not enforce this
    logic [14:0] r_bypass_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass_lim <= '0;
        end else if (i_cfg_we) begin
            r_bypass_lim <= i_cfg_wdata;
        end
    end

    logic        lim_all;
    logic [63:0] lim_q62;
    assign lim_all = (r_bypass_lim >> ARG_FRAC_BITS) != '0;
    assign lim_q62 = 64'(r_bypass_lim) << (62 - ARG_FRAC_BITS);

    // stage 1: sign split and saturated magnitude
    fpa_pkg::t_ctx r_s1_ctx, n_s1_ctx;
    logic [31:0]   n_mag;

    always_comb begin
        n_mag = i_arg_value[31] ? (~i_arg_value + 32'd1) : i_arg_value;
        // most negative argument has no positive twin
        if (n_mag[31]) begin
            n_mag = 32'h7FFF_FFFF;
        end
        n_s1_ctx         = '0;
        n_s1_ctx.valid   = i_arg_valid;
        n_s1_ctx.arg_neg = i_arg_value[31];
        n_s1_ctx.mag     = n_mag;
        n_s1_ctx.invert  = n_mag > ONE_ARG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctx.valid <= 1'b0;
        end else if (en) begin
            r_s1_ctx <= n_s1_ctx;
        end
    end

    // reciprocal of the magnitude, used only when above one
    logic [fpa_pkg::Q_BITS-1:0] d1_q;
    fpa_pkg::t_ctx              d1_ctx;

    fpa_div #(.W(32)) u_div_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (ONE_ARG),
        .i_den   (r_s1_ctx.mag),
        .i_ctx   (r_s1_ctx),
        .o_q     (d1_q),
        .o_ctx   (d1_ctx)
    );

    // t in Q62, then the tan(pi/12) test
    fpa_pkg::t_ctx r_t1_ctx, n_t1_ctx, r_t2_ctx, n_t2_ctx;

    always_comb begin
        n_t1_ctx   = d1_ctx;
        n_t1_ctx.t = d1_ctx.invert ? ((64'(d1_q) + 64'd1) >> 1)
                                   : (64'(d1_ctx.mag) << (62 - ARG_FRAC_BITS));
        n_t2_ctx       = r_t1_ctx;
        n_t2_ctx.sixth = r_t1_ctx.t > fpa_pkg::C_TAN15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_ctx.valid <= 1'b0;
            r_t2_ctx.valid <= 1'b0;
        end else if (en) begin
            r_t1_ctx <= n_t1_ctx;
            r_t2_ctx <= n_t2_ctx;
        end
    end

    // t * sqrt3 for the pi/6 shift
    logic signed [63:0] m1_p;
    fpa_pkg::t_ctx      m1_ctx;

    fpa_mul u_mul_sqrt3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     ($signed(r_t2_ctx.t)),
        .i_b     ($signed(fpa_pkg::C_SQRT3)),
        .i_ctx   (r_t2_ctx),
        .o_p     (m1_p),
        .o_ctx   (m1_ctx)
    );

    // numerator |t*sqrt3 - 1| and denominator sqrt3 + t
    fpa_pkg::t_ctx r_n_ctx, n_n_ctx;
    logic [63:0]   r_n_num, r_n_den, n_n_num;

    always_comb begin
        n_n_ctx       = m1_ctx;
        n_n_ctx.r_neg = 64'(m1_p) < fpa_pkg::ONE_Q62;
        n_n_num       = n_n_ctx.r_neg ? (fpa_pkg::ONE_Q62 - 64'(m1_p))
                                      : (64'(m1_p) - fpa_pkg::ONE_Q62);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_ctx.valid <= 1'b0;
        end else if (en) begin
            r_n_ctx <= n_n_ctx;
            r_n_num <= n_n_num;
            r_n_den <= fpa_pkg::C_SQRT3 + m1_ctx.t;
        end
    end

    logic [fpa_pkg::Q_BITS-1:0] d2_q;
    fpa_pkg::t_ctx              d2_ctx;

    fpa_div #(.W(64)) u_div_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .i_ctx   (r_n_ctx),
        .o_q     (d2_q),
        .o_ctx   (d2_ctx)
    );

    // reduced magnitude, then signed r and the bypass decision
    fpa_pkg::t_ctx r_r1_ctx, n_r1_ctx, r_r2_ctx, n_r2_ctx;

    always_comb begin
        n_r1_ctx       = d2_ctx;
        n_r1_ctx.r     = d2_ctx.sixth ? ((64'(d2_q) + 64'd1) >> 1) : d2_ctx.t;
        n_r1_ctx.r_neg = d2_ctx.sixth && d2_ctx.r_neg;
        n_r2_ctx        = r_r1_ctx;
        n_r2_ctx.r      = r_r1_ctx.r_neg ? (64'd0 - r_r1_ctx.r) : r_r1_ctx.r;
        n_r2_ctx.bypass = lim_all || (r_r1_ctx.r < lim_q62);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_ctx.valid <= 1'b0;
            r_r2_ctx.valid <= 1'b0;
        end else if (en) begin
            r_r1_ctx <= n_r1_ctx;
            r_r2_ctx <= n_r2_ctx;
        end
    end

    // z = r*r
    logic signed [63:0] mz_p;
    fpa_pkg::t_ctx      mz_ctx;
    fpa_pkg::t_ctx      r_z_ctx, n_z_ctx;

    fpa_mul u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     ($signed(r_r2_ctx.r)),
        .i_b     ($signed(r_r2_ctx.r)),
        .i_ctx   (r_r2_ctx),
        .o_p     (mz_p),
        .o_ctx   (mz_ctx)
    );

    always_comb begin
        n_z_ctx   = mz_ctx;
        n_z_ctx.z = 64'(mz_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_ctx.valid <= 1'b0;
        end else if (en) begin
            r_z_ctx <= n_z_ctx;
        end
    end

    // horner chain: p = c[i] + p*z, highest coefficient first
    fpa_pkg::t_ctx      h_ctx [POLY_DEGREE+1];
    logic signed [63:0] h_p   [POLY_DEGREE+1];

    assign h_ctx[0] = r_z_ctx;
    assign h_p[0]   = fpa_pkg::C_COEF[POLY_DEGREE];

    for (genvar j = 0; j < POLY_DEGREE; j++) begin : g_horner
        logic signed [63:0] m_p;
        fpa_pkg::t_ctx      m_ctx;
        logic signed [63:0] r_p;
        fpa_pkg::t_ctx      r_ctx;

        fpa_mul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_a     (h_p[j]),
            .i_b     ($signed(h_ctx[j].z)),
            .i_ctx   (h_ctx[j]),
            .o_p     (m_p),
            .o_ctx   (m_ctx)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctx.valid <= 1'b0;
            end else if (en) begin
                r_ctx <= m_ctx;
                r_p   <= m_p + fpa_pkg::C_COEF[POLY_DEGREE-1-j];
            end
        end

        assign h_ctx[j+1] = r_ctx;
        assign h_p[j+1]   = r_p;
    end

    // r * p
    logic signed [63:0] mf_p;
    fpa_pkg::t_ctx      mf_ctx;

    fpa_mul u_mul_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     ($signed(h_ctx[POLY_DEGREE].r)),
        .i_b     (h_p[POLY_DEGREE]),
        .i_ctx   (h_ctx[POLY_DEGREE]),
        .o_p     (mf_p),
        .o_ctx   (mf_ctx)
    );

    // choose r or r*p by the bypass flag, undo the range reduction, then round to the output format
    fpa_pkg::t_ctx      r_f1_ctx, r_f2_ctx, r_f3_ctx, r_f4_ctx;
    logic signed [63:0] r_f1_a, r_f2_a;
    logic signed [63:0] n_f1_a, n_f2_a;
    logic [63:0]        r_f3_mag, r_f4_rm;
    logic               r_f3_neg, r_f4_neg;
    logic [63:0]        n_f3_mag;
    logic               n_f3_neg;
    logic               r_out_valid;
    logic signed [AW-1:0] r_out_value;

    always_comb begin
        n_f1_a = (mf_ctx.bypass ? $signed(mf_ctx.r) : mf_p)
               + (mf_ctx.sixth ? $signed(fpa_pkg::C_SIXTH_PI) : 64'sd0);
        n_f2_a = r_f1_ctx.invert ? ($signed(fpa_pkg::C_HALF_PI) - r_f1_a) : r_f1_a;
        n_f3_mag = r_f2_a[63] ? 64'(-r_f2_a) : 64'(r_f2_a);
        // sign of the final angle after restoring the argument sign
        n_f3_neg = r_f2_ctx.arg_neg ? (!r_f2_a[63] && (r_f2_a != 64'sd0)) : r_f2_a[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_ctx.valid <= 1'b0;
            r_f2_ctx.valid <= 1'b0;
            r_f3_ctx.valid <= 1'b0;
            r_f4_ctx.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else if (en) begin
            r_f1_ctx    <= mf_ctx;
            r_f1_a      <= n_f1_a;
            r_f2_ctx    <= r_f1_ctx;
            r_f2_a      <= n_f2_a;
            r_f3_ctx    <= r_f2_ctx;
            r_f3_mag    <= n_f3_mag;
            r_f3_neg    <= n_f3_neg;
            r_f4_ctx    <= r_f3_ctx;
            r_f4_rm     <= (r_f3_mag + RND_OUT) >> SH;
            r_f4_neg    <= r_f3_neg;
            r_out_valid <= r_f4_ctx.valid;
            r_out_value <= r_f4_neg ? -$signed(r_f4_rm[AW-1:0]) : $signed(r_f4_rm[AW-1:0]);
        end
    end

    assign o_angle_valid = r_out_valid;
    assign o_angle_value = r_out_value;

    // checks
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_angle_valid)
        else $error("result valid right after reset");

    a_held_result_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle_valid && !i_angle_ready) |-> !o_arg_ready)
        else $error("input taken while a result is held");

    a_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t1_ctx.valid |-> (r_t1_ctx.t <= fpa_pkg::ONE_Q62))
        else $error("reduced argument above one");

    a_r_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r1_ctx.valid && r_r1_ctx.sixth) |-> (r_r1_ctx.r < fpa_pkg::HALF_Q62))
        else $error("pi/6 reduction out of range");

endmodule
